// ===== hdl/sus_pkg.sv =====
package sus_pkg;

	// command codes as seen on the input
	localparam logic [2:0] FN_APPEND_A  = 3'd0;
	localparam logic [2:0] FN_APPEND_B  = 3'd1;
	localparam logic [2:0] FN_UNION     = 3'd2;
	localparam logic [2:0] FN_INTERSECT = 3'd3;
	localparam logic [2:0] FN_CLEAR     = 3'd4;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [2:0]         func;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] value_res;
		logic               last;
		logic               none;
		logic               overflow;
	} result_t;

	// head of the command queue as the back end sees it
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} queue_head_t;

endpackage

// ===== hdl/sus_ram.sv =====
module sus_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read returning old data on collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/sus_front.sv =====
module sus_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  sus_pkg::cmd_t       cmd,
	output sus_pkg::queue_head_t head,
	input  logic                pop
);
	import sus_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              known_func;
	logic              push;
	logic              do_pop;

	// classify: only defined codes are queued, the rest are consumed here
	always_comb begin
		case (cmd.func)
			FN_APPEND_A, FN_APPEND_B, FN_UNION, FN_INTERSECT, FN_CLEAR: known_func = 1'b1;
			default: known_func = 1'b0;
		endcase
	end

	assign busy   = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign push   = start && !busy && known_func;
	assign do_pop = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.cmd   = entry_q[rd_ptr_q];

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd;
		end
	end

endmodule

// ===== hdl/sus_back.sv =====
module sus_back #(
	parameter int LIST_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sus_pkg::queue_head_t head,
	output logic                 pop,
	output sus_pkg::result_t     result,
	output logic                 result_strobe
);
	import sus_pkg::*;

	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_PRIME = 2'd1;
	localparam logic [1:0] ST_MERGE = 2'd2;

	logic [1:0]         state_q;
	logic [CW-1:0]      count_a_q;
	logic [CW-1:0]      count_b_q;
	logic               dropped_q;
	logic [CW-1:0]      ia_q;
	logic [CW-1:0]      ib_q;
	logic               union_q;
	logic               pend_valid_q;
	logic signed [31:0] pend_val_q;
	result_t            res_q;
	logic               strobe_q;

	logic [CW-1:0]      ia_d;
	logic [CW-1:0]      ib_d;
	logic               we_a;
	logic               we_b;
	logic [31:0]        rdata_a;
	logic [31:0]        rdata_b;
	logic               a_ok;
	logic               b_ok;
	logic               adv_a;
	logic               adv_b;
	logic               emit;
	logic signed [31:0] emit_val;
	logic               finish;
	logic               a_room;
	logic               b_room;

	assign pop    = (state_q == ST_IDLE) && head.valid;
	assign a_room = (count_a_q < CW'(LIST_DEPTH));
	assign b_room = (count_b_q < CW'(LIST_DEPTH));
	assign we_a   = pop && (head.cmd.func == FN_APPEND_A) && a_room;
	assign we_b   = pop && (head.cmd.func == FN_APPEND_B) && b_room;

	assign ia_d = ia_q + CW'(adv_a);
	assign ib_d = ib_q + CW'(adv_b);

	sus_ram #(.WIDTH(32), .DEPTH(LIST_DEPTH), .AW(AW)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (count_a_q[AW-1:0]),
		.wdata (head.cmd.value),
		.raddr (ia_d[AW-1:0]),
		.rdata (rdata_a)
	);

	sus_ram #(.WIDTH(32), .DEPTH(LIST_DEPTH), .AW(AW)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (count_b_q[AW-1:0]),
		.wdata (head.cmd.value),
		.raddr (ib_d[AW-1:0]),
		.rdata (rdata_b)
	);

	// one head comparison per merge cycle
	always_comb begin
		a_ok     = (ia_q < count_a_q);
		b_ok     = (ib_q < count_b_q);
		adv_a    = 1'b0;
		adv_b    = 1'b0;
		emit     = 1'b0;
		emit_val = rdata_a;
		finish   = 1'b0;
		if (state_q == ST_MERGE) begin
			if (a_ok && b_ok) begin
				if (rdata_a == rdata_b) begin
					adv_a = 1'b1;
					adv_b = 1'b1;
					emit  = 1'b1;
				end else if ($signed(rdata_a) < $signed(rdata_b)) begin
					adv_a = 1'b1;
					emit  = union_q;
				end else begin
					adv_b    = 1'b1;
					emit     = union_q;
					emit_val = rdata_b;
				end
			end else if (union_q && a_ok) begin
				adv_a = 1'b1;
				emit  = 1'b1;
			end else if (union_q && b_ok) begin
				adv_b    = 1'b1;
				emit     = 1'b1;
				emit_val = rdata_b;
			end else begin
				finish = 1'b1;
			end
		end
	end

	// sequencer, list counts and sticky overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_a_q    <= '0;
			count_b_q    <= '0;
			dropped_q    <= 1'b0;
			ia_q         <= '0;
			ib_q         <= '0;
			union_q      <= 1'b0;
			pend_valid_q <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (head.cmd.func)
							FN_APPEND_A: begin
								if (a_room) begin
									count_a_q <= count_a_q + 1'b1;
								end else begin
									dropped_q <= 1'b1;
								end
							end
							FN_APPEND_B: begin
								if (b_room) begin
									count_b_q <= count_b_q + 1'b1;
								end else begin
									dropped_q <= 1'b1;
								end
							end
							FN_UNION, FN_INTERSECT: begin
								union_q      <= (head.cmd.func == FN_UNION);
								ia_q         <= '0;
								ib_q         <= '0;
								pend_valid_q <= 1'b0;
								state_q      <= ST_PRIME;
							end
							FN_CLEAR: begin
								count_a_q <= '0;
								count_b_q <= '0;
								dropped_q <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_PRIME: begin
					state_q <= ST_MERGE;
				end
				ST_MERGE: begin
					ia_q <= ia_d;
					ib_q <= ib_d;
					if (emit) begin
						pend_valid_q <= 1'b1;
						strobe_q     <= pend_valid_q;
					end
					if (finish) begin
						strobe_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload: one item is held back so the final one can carry last
	always_ff @(posedge clk) begin
		if (state_q == ST_MERGE) begin
			if (emit) begin
				pend_val_q      <= emit_val;
				res_q.value_res <= pend_val_q;
				res_q.last      <= 1'b0;
				res_q.none      <= 1'b0;
				res_q.overflow  <= dropped_q;
			end
			if (finish) begin
				res_q.value_res <= pend_valid_q ? pend_val_q : '0;
				res_q.last      <= 1'b1;
				res_q.none      <= !pend_valid_q;
				res_q.overflow  <= dropped_q;
			end
		end
	end

	assign result        = res_q;
	assign result_strobe = strobe_q;

endmodule

// ===== hdl/sorted_set_union_intersection.sv =====
// Sorted set union / intersection engine. Commands enter on start while busy is low and go
// into a four-entry queue; busy rises only when that queue is full. Unknown codes are accepted
// and dropped at the front end without reaching the queue. Appends and clears are done in the
// back end as they are taken from the queue. A run is taken from the queue, then primes the
// list memories, then makes one head comparison per step (count_a + count_b at most) and
// ends with a closing step that gives the item marked last; the queue blocks new commands only
// once four are waiting. Results appear one per cycle at most, each on result for exactly one
// cycle with result_strobe high; the receiver cannot stall them, and the last item of every
// run carries last. An empty result is a single item with none and last set.
// overflow reports a dropped append since the last clear on every result item.
module sorted_set_union_intersection #(
	parameter int LIST_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  sus_pkg::cmd_t    cmd,
	output sus_pkg::result_t result,
	output logic             result_strobe
);
	import sus_pkg::*;

	queue_head_t head;
	logic        pop;

	// front end: accept and classify commands into the queue
	sus_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.head   (head),
		.pop    (pop)
	);

	// back end: list storage and merge sequencer
	sus_back #(.LIST_DEPTH(LIST_DEPTH)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.result        (result),
		.result_strobe (result_strobe)
	);

	// an empty run gives one closing item with a zero value
	a_none_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.none |-> result.last && (result.value_res == '0))
		else $error("empty-result item not marked last or value not zero");

	// back end never takes a transaction from an empty queue
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("pop with empty command queue");

	// the closing item of a run is followed by a quiet cycle
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.last |=> !result_strobe)
		else $error("result strobe right after last item");

endmodule

// ===== verif/sorted_set_union_intersection_test.sv =====
module sorted_set_union_intersection_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sus_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam int RANDOM_ITEMS = 280;
	localparam int POOL_MAX = 22;
	localparam int TAIL_ITEMS = 40;
	localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 32;

	// codes past clear do nothing in the block
	localparam logic [2:0] FN_FIRST_UNUSED = FN_CLEAR + 3'd1;
	localparam logic [2:0] FN_LAST_CODE = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	cmd_t cmd = '0;
	result_t result;
	logic result_strobe;

	sorted_set_union_intersection #(
		.LIST_DEPTH(LIST_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.result(result),
		.result_strobe(result_strobe)
	);

	// shadow copy of the two lists and the sticky drop flag
	logic signed [31:0] shadow_a [LIST_DEPTH];
	logic signed [31:0] shadow_b [LIST_DEPTH];
	int shadow_count_a = 0;
	int shadow_count_b = 0;
	logic shadow_dropped = 1'b0;

	cmd_t commands_to_send [$];
	result_t set_results_due [$];

	int idle_left = 0;
	int useful_items = 0;
	int sent_count = 0;
	int run_count = 0;
	int empty_runs = 0;
	int overflow_runs = 0;
	int compared_count = 0;
	int mismatch_count = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic push_command(input logic [2:0] f, input logic signed [31:0] v);
		cmd_t c;
		c.func = f;
		c.value = v;
		commands_to_send.push_back(c);
		if (f <= FN_CLEAR)
			useful_items++;
	endtask

	function automatic logic signed [31:0] rand_element(input int mode);
		logic [31:0] r;
		r = $urandom_range(0, 7);
		case (mode)
			0: return $urandom;
			1: return 32'($urandom_range(0, 40)) - 32'sd20;
			default: return $urandom_range(0, 1) ? 32'h8000_0000 + r : 32'h7fff_fff8 + r;
		endcase
	endfunction

	// apply one accepted transaction to the shadow lists and queue what it produces
	task automatic compute_set_results(input cmd_t c);
		logic signed [31:0] merged [$];
		logic signed [31:0] a, b;
		logic is_union;
		int ia, ib;
		result_t r;
		case (c.func)
			FN_APPEND_A: begin
				if (shadow_count_a >= LIST_DEPTH) begin
					shadow_dropped = 1'b1;
				end else begin
					shadow_a[shadow_count_a] = c.value;
					shadow_count_a++;
				end
			end
			FN_APPEND_B: begin
				if (shadow_count_b >= LIST_DEPTH) begin
					shadow_dropped = 1'b1;
				end else begin
					shadow_b[shadow_count_b] = c.value;
					shadow_count_b++;
				end
			end
			FN_UNION, FN_INTERSECT: begin
				is_union = (c.func == FN_UNION);
				ia = 0;
				ib = 0;
				// head-by-head merge, equal heads emitted once
				while (ia < shadow_count_a && ib < shadow_count_b) begin
					a = shadow_a[ia];
					b = shadow_b[ib];
					if (a == b) begin
						merged.push_back(a);
						ia++;
						ib++;
					end else if (a < b) begin
						if (is_union)
							merged.push_back(a);
						ia++;
					end else begin
						if (is_union)
							merged.push_back(b);
						ib++;
					end
				end
				// tails only matter for union
				if (is_union) begin
					while (ia < shadow_count_a) begin
						merged.push_back(shadow_a[ia]);
						ia++;
					end
					while (ib < shadow_count_b) begin
						merged.push_back(shadow_b[ib]);
						ib++;
					end
				end
				run_count++;
				if (shadow_dropped)
					overflow_runs++;
				r.overflow = shadow_dropped;
				if (merged.size() == 0) begin
					empty_runs++;
					r.value_res = '0;
					r.last = 1'b1;
					r.none = 1'b1;
					set_results_due.push_back(r);
				end else begin
					r.none = 1'b0;
					foreach (merged[k]) begin
						r.value_res = merged[k];
						r.last = (k == merged.size() - 1);
						set_results_due.push_back(r);
					end
				end
			end
			FN_CLEAR: begin
				shadow_count_a = 0;
				shadow_count_b = 0;
				shadow_dropped = 1'b0;
			end
			default: begin
			end
		endcase
	endtask

	// driver: one transaction per start/busy handshake, random idle bursts
	always @(posedge clk or negedge arst_n) begin : drive
		logic next_start;
		cmd_t next_cmd;
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
			idle_left <= 0;
		end else begin
			next_start = start;
			next_cmd = cmd;
			if (start && !busy) begin
				compute_set_results(cmd);
				sent_count++;
				next_start = 1'b0;
			end
			if (!next_start) begin
				if (idle_left > 0) begin
					idle_left <= idle_left - 1;
				end else if (commands_to_send.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
					idle_left <= $urandom_range(0, 15);
				end else if (commands_to_send.size() != 0) begin
					next_start = 1'b1;
					next_cmd = commands_to_send.pop_front();
				end
			end
			start <= next_start;
			cmd <= next_cmd;
		end
	end

	// monitor: every strobed result is checked against the oldest prediction
	always @(posedge clk) begin : watch
		result_t want;
		if (arst_n && result_strobe) begin
			if (set_results_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result value_res=%0d last=%b none=%b",
					result.value_res, result.last, result.none));
			end else begin
				want = set_results_due.pop_front();
				compared_count++;
				if (result.value_res !== want.value_res)
					report_mismatch($sformatf("value_res got %0d want %0d",
						result.value_res, want.value_res));
				if (result.last !== want.last)
					report_mismatch($sformatf("last got %b want %b", result.last, want.last));
				if (result.none !== want.none)
					report_mismatch($sformatf("none got %b want %b", result.none, want.none));
				if (result.overflow !== want.overflow)
					report_mismatch($sformatf("overflow got %b want %b",
						result.overflow, want.overflow));
			end
		end
	end

	initial begin : stimulus
		logic signed [31:0] pool [POOL_MAX];
		logic signed [31:0] swap;
		int pool_size, mode, keep_a, keep_b, runs, target;

		// directed: empty lists, extremes, unused codes, single elements, unsorted input
		push_command(FN_UNION, 32'h7fff_ffff);
		push_command(FN_INTERSECT, 32'h8000_0000);
		push_command(FN_APPEND_A, 32'h8000_0000);
		push_command(FN_APPEND_A, -32'sd1);
		push_command(FN_APPEND_A, 32'sd0);
		push_command(FN_APPEND_A, 32'h7fff_ffff);
		push_command(FN_APPEND_B, 32'h8000_0000);
		push_command(FN_APPEND_B, 32'sd5);
		push_command(FN_APPEND_B, 32'h7fff_ffff);
		push_command(FN_UNION, '0);
		push_command(FN_INTERSECT, '1);
		push_command(FN_FIRST_UNUSED, '1);
		push_command(FN_FIRST_UNUSED + 3'd1, 32'h8000_0000);
		push_command(FN_LAST_CODE, 32'h7fff_ffff);
		push_command(FN_CLEAR, '1);
		push_command(FN_APPEND_A, 32'sd1);
		push_command(FN_INTERSECT, '0);
		push_command(FN_UNION, '0);
		push_command(FN_APPEND_B, 32'sd1);
		push_command(FN_INTERSECT, '0);
		push_command(FN_APPEND_B, -32'sd7);
		push_command(FN_UNION, '0);

		// random: mostly clear, load two sorted subsets of a shared pool, then run
		target = useful_items + RANDOM_ITEMS;
		while (useful_items < target) begin
			if ($urandom_range(0, 5) != 0)
				push_command(FN_CLEAR, $urandom);
			pool_size = ($urandom_range(0, 5) == 0) ? $urandom_range(14, POOL_MAX)
				: $urandom_range(0, 10);
			mode = $urandom_range(0, 2);
			for (int i = 0; i < pool_size; i++) begin
				pool[i] = rand_element(mode);
				for (int j = i; j > 0 && pool[j] < pool[j - 1]; j--) begin
					swap = pool[j];
					pool[j] = pool[j - 1];
					pool[j - 1] = swap;
				end
			end
			// occasionally break the ordering
			if (pool_size > 1 && $urandom_range(0, 7) == 0) begin
				swap = pool[0];
				pool[0] = pool[pool_size - 1];
				pool[pool_size - 1] = swap;
			end
			keep_a = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(40, 100);
			keep_b = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(40, 100);
			for (int i = 0; i < pool_size; i++) begin
				if ($urandom_range(1, 100) <= keep_a)
					push_command(FN_APPEND_A, pool[i]);
			end
			for (int i = 0; i < pool_size; i++) begin
				if ($urandom_range(1, 100) <= keep_b)
					push_command(FN_APPEND_B, pool[i]);
			end
			if ($urandom_range(0, 9) == 0)
				push_command(3'($urandom_range(FN_FIRST_UNUSED, FN_LAST_CODE)), $urandom);
			runs = $urandom_range(1, 3);
			repeat (runs)
				push_command($urandom_range(0, 1) ? FN_UNION : FN_INTERSECT, $urandom);
		end

		// drain: everything sent, every prediction met, then a quiet stretch
		wait (arst_n);
		while (commands_to_send.size() != 0 || start)
			@(posedge clk);
		while (set_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d commands, including %0d union/intersection runs", sent_count, run_count);
		$display("compared %0d result items; %0d runs came back empty, %0d with overflow set",
			compared_count, empty_runs, overflow_runs);
		if (mismatch_count == 0 && set_results_due.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("timed out with %0d results still due", set_results_due.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
